// ===== src/vsa_pkg.sv =====
// ----------------------------------------------------------------------------
// vsa_pkg: shared types and constants of the voice slot allocator
// Slot count, field widths, status codes, register indexes and FSM states.
// ----------------------------------------------------------------------------
package vsa_pkg;

  // Slot table geometry
  localparam int SLOTS   = 32;
  localparam int SLOT_W  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int LIM_W   = 6;
  localparam int CMP_W   = (CNT_W > LIM_W) ? CNT_W : LIM_W;

  // Field widths
  localparam int ID_W    = 16;
  localparam int AGE_W   = 15;
  localparam int MASK_W  = 32;
  localparam int STAT_W  = 3;
  localparam int OSLOT_W = 5;
  localparam int ENT_W   = ID_W + AGE_W;

  localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

  // Configuration port
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SOUND_COUNT    = 1'b0,
    CFG_INSTANCE_LIMIT = 1'b1
  } cfg_idx_e;

  localparam logic [LIM_W-1:0] LIMIT_RESET = LIM_W'(4);

  // Commands of an input item
  typedef enum logic {
    CMD_ALLOC = 1'b0,
    CMD_TICK  = 1'b1
  } cmd_e;

  // Result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_FREE   = 3'd0,
    ST_STOLEN = 3'd1,
    ST_BAD_ID = 3'd2,
    ST_NONE   = 3'd3,
    ST_TICK   = 3'd4
  } status_e;

  // Sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_WAIT,
    S_DONE
  } state_e;

endpackage

// ===== src/vsa_if.sv =====
// ----------------------------------------------------------------------------
// vsa_if: valid/ready channels of the voice slot allocator
// One interface for request items and one for result items.
// ----------------------------------------------------------------------------
interface vsa_req_if
  import vsa_pkg::*;
  ();
  logic              valid;
  logic              ready;
  logic              cmd;
  logic [ID_W-1:0]   sound_id;
  logic [MASK_W-1:0] playing_mask;

  modport source (output valid, output cmd, output sound_id, output playing_mask,
                  input ready);
  modport sink   (input valid, input cmd, input sound_id, input playing_mask,
                  output ready);
endinterface

interface vsa_rsp_if
  import vsa_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic [STAT_W-1:0]  status;
  logic [OSLOT_W-1:0] slot;

  modport source (output valid, output status, output slot, input ready);
  modport sink   (input valid, input status, input slot, output ready);
endinterface

// ===== src/voice_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// voice_slot_allocator: sound voice slot table with instance limit
// Grants free voice slots, steals the oldest instance of an over-limit id
// and ages or frees slots on each tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_chan (sink) takes one item: cmd 0 allocates a slot for sound_id,
//   cmd 1 ticks all slots with playing_mask. rsp_chan (source) returns
//   exactly one item per request: status and slot.
//   cfg_we_i/cfg_idx_i/cfg_data_i write sound_count (index 0) and
//   instance_limit (index 1); write only while the block is idle.
// Operation:
//   Slot sound and age live in a one-port-read, one-port-write RAM; each
//   scanned request reads all SLOTS entries one per cycle, then passes a
//   wait state and a done state that loads the result; an allocate with a
//   rejected id goes straight to the done state. One request is worked at
//   a time: no new request is taken until the last result is loaded.
// Reset:
//   All slots become free at once (valid bits in flops), sound_count is 0
//   and instance_limit is 4. No clearing pass is needed.
// Stall:
//   The result register holds until taken; a new request is accepted while
//   it waits, and its own result waits until the register drains.
// ----------------------------------------------------------------------------
module voice_slot_allocator
  import vsa_pkg::*;
(
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_data_i,
  vsa_req_if.sink               req_chan,
  vsa_rsp_if.source             rsp_chan
);

  // Configuration registers
  logic [ID_W-1:0]  sound_count_q;
  logic [LIM_W-1:0] limit_q;

  // Sequencer
  state_e state_q, state_d;
  logic   accept;
  logic   rd_en;
  logic   done_fire;
  logic   out_free;

  // Latched request
  logic              cmd_q;
  logic [ID_W-1:0]   id_q;
  logic [MASK_W-1:0] mask_q;
  logic              bad_q;
  logic              bad_id;

  // Scan pointer and processing stage
  logic [SLOT_W-1:0] cnt_q;
  logic              proc_vld_q;
  logic [SLOT_W-1:0] proc_idx_q;

  // Slot store
  logic [SLOTS-1:0]  valid_q, valid_d;
  logic [ENT_W-1:0]  mem_q [SLOTS];
  logic [ENT_W-1:0]  rd_data_q;
  logic              wr_en;
  logic [SLOT_W-1:0] wr_addr;
  logic [ENT_W-1:0]  wr_data;

  // Scan accumulators
  logic              have_free_q, have_free_d;
  logic [SLOT_W-1:0] free_idx_q, free_idx_d;
  logic [CNT_W-1:0]  match_cnt_q, match_cnt_d;
  logic              have_old_q, have_old_d;
  logic [SLOT_W-1:0] old_idx_q, old_idx_d;
  logic [AGE_W-1:0]  old_age_q, old_age_d;

  // Processing stage view of the entry
  logic              pv;
  logic              playing;
  logic [ID_W-1:0]   ent_sound;
  logic [AGE_W-1:0]  ent_age;
  logic [AGE_W-1:0]  age_inc;

  // Result selection
  logic [LIM_W-1:0]  limit_eff;
  logic              steal;
  status_e           res_status;
  logic [SLOT_W-1:0] res_slot;
  logic              res_write;

  // Output register
  logic               out_valid_q;
  logic [STAT_W-1:0]  out_status_q;
  logic [OSLOT_W-1:0] out_slot_q;

  // --------------------------------------------------------------------------
  // Configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sound_count_q <= '0;
      limit_q       <= LIMIT_RESET;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_e'(cfg_idx_i))
        CFG_SOUND_COUNT:    sound_count_q <= cfg_data_i[ID_W-1:0];
        CFG_INSTANCE_LIMIT: limit_q       <= cfg_data_i[LIM_W-1:0];
        default:            ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake helpers
  assign accept   = req_chan.valid && req_chan.ready;
  assign out_free = !out_valid_q || rsp_chan.ready;
  assign bad_id   = (req_chan.sound_id == '0) || (req_chan.sound_id >= sound_count_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (req_chan.cmd == CMD_ALLOC && bad_id) state_d = S_DONE;
          else                                     state_d = S_SCAN;
        end
      end
      S_SCAN: begin
        if (cnt_q == SLOT_W'(SLOTS - 1)) state_d = S_WAIT;
      end
      S_WAIT: state_d = S_DONE;
      S_DONE: begin
        if (out_free) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Sequencer outputs
  always_comb begin
    req_chan.ready = 1'b0;
    rd_en          = 1'b0;
    done_fire      = 1'b0;
    unique case (state_q)
      S_IDLE:  req_chan.ready = 1'b1;
      S_SCAN:  rd_en          = 1'b1;
      S_WAIT:  ;
      S_DONE:  done_fire      = out_free;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= S_IDLE;
      cnt_q      <= '0;
      proc_vld_q <= 1'b0;
      proc_idx_q <= '0;
    end else begin
      state_q    <= state_d;
      proc_vld_q <= rd_en;
      proc_idx_q <= cnt_q;
      if (accept)     cnt_q <= '0;
      else if (rd_en) cnt_q <= cnt_q + SLOT_W'(1);
    end
  end

  // Latch the request payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q  <= req_chan.cmd;
      id_q   <= req_chan.sound_id;
      mask_q <= req_chan.playing_mask;
      bad_q  <= (req_chan.cmd == CMD_ALLOC) && bad_id;
    end
  end

  // --------------------------------------------------------------------------
  // Slot RAM: one read and one write port, registered read data
  always_ff @(posedge clk_i) begin
    if (wr_en) mem_q[wr_addr] <= wr_data;
    if (rd_en) rd_data_q <= mem_q[cnt_q];
  end

  // Split the entry read in the previous cycle
  assign pv        = valid_q[proc_idx_q];
  assign ent_sound = rd_data_q[ENT_W-1:AGE_W];
  assign ent_age   = rd_data_q[AGE_W-1:0];
  assign age_inc   = (ent_age == AGE_MAX) ? ent_age : ent_age + AGE_W'(1);
  assign playing   = mask_q[proc_idx_q];

  // Final choice of a request's result: bad id, tick or allocate grant
  assign limit_eff  = (limit_q == '0) ? LIM_W'(1) : limit_q;
  assign steal      = have_old_q && (CMP_W'(match_cnt_q) >= CMP_W'(limit_eff));

  always_comb begin
    res_status = ST_TICK;
    res_slot   = '0;
    res_write  = 1'b0;
    if (bad_q) begin
      res_status = ST_BAD_ID;
    end else if (cmd_q == CMD_ALLOC) begin
      if (steal) begin
        res_status = ST_STOLEN;
        res_slot   = old_idx_q;
        res_write  = 1'b1;
      end else if (have_free_q) begin
        res_status = ST_FREE;
        res_slot   = free_idx_q;
        res_write  = 1'b1;
      end else begin
        res_status = ST_NONE;
      end
    end
  end

  // Process the scanned entry and the final write-back
  always_comb begin
    valid_d     = valid_q;
    wr_en       = 1'b0;
    wr_addr     = proc_idx_q;
    wr_data     = {ent_sound, age_inc};
    have_free_d = have_free_q;
    free_idx_d  = free_idx_q;
    match_cnt_d = match_cnt_q;
    have_old_d  = have_old_q;
    old_idx_d   = old_idx_q;
    old_age_d   = old_age_q;

    if (proc_vld_q) begin
      if (cmd_q == CMD_TICK) begin
        // age a live voice, free a stopped one
        if (pv && playing) wr_en = 1'b1;
        else               valid_d[proc_idx_q] = 1'b0;
      end else if (!pv) begin
        have_free_d = 1'b1;
        free_idx_d  = proc_idx_q;
      end else if (ent_sound == id_q) begin
        match_cnt_d = match_cnt_q + CNT_W'(1);
        if (!have_old_q || ent_age > old_age_q) begin
          have_old_d = 1'b1;
          old_idx_d  = proc_idx_q;
          old_age_d  = ent_age;
        end
      end
    end

    // claim the chosen slot
    if (done_fire && res_write) begin
      wr_en             = 1'b1;
      wr_addr           = res_slot;
      wr_data           = {id_q, {AGE_W{1'b0}}};
      valid_d[res_slot] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q     <= '0;
      have_free_q <= 1'b0;
      match_cnt_q <= '0;
      have_old_q  <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (accept) begin
        have_free_q <= 1'b0;
        match_cnt_q <= '0;
        have_old_q  <= 1'b0;
      end else begin
        have_free_q <= have_free_d;
        match_cnt_q <= match_cnt_d;
        have_old_q  <= have_old_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    old_idx_q  <= old_idx_d;
    old_age_q  <= old_age_d;
  end

  // --------------------------------------------------------------------------
  // Result register: load on completion, drop when taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (done_fire) begin
      out_valid_q <= 1'b1;
    end else if (rsp_chan.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (done_fire) begin
      out_status_q <= res_status;
      out_slot_q   <= OSLOT_W'(res_slot);
    end
  end

  assign rsp_chan.valid  = out_valid_q;
  assign rsp_chan.status = out_status_q;
  assign rsp_chan.slot   = out_slot_q;

endmodule

// ===== sim/tb_voice_slot_allocator.sv =====
// ----------------------------------------------------------------------------
// tb_voice_slot_allocator: self-checking bench for the voice slot allocator
// Drives allocate and tick items through the request channel, predicts every
// result with a local model of the slot table and compares each returned
// item field by field. Runs a directed part, then random phases under
// several register settings and idle/stall patterns.
// ----------------------------------------------------------------------------
module tb_voice_slot_allocator;
  import vsa_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int PHASE_ITEMS  = 110;
  localparam int DRAIN_CYCLES = 40;
  localparam int PRINT_CAP    = 40;

  typedef struct packed {
    status_e            status;
    logic [OSLOT_W-1:0] slot;
  } voice_grant_t;

  // Slot table predictor and queue of expected grants
  class voice_table_board;
    logic               live  [SLOTS];
    logic [ID_W-1:0]    owner [SLOTS];
    logic [AGE_W-1:0]   age   [SLOTS];
    logic [ID_W-1:0]    id_bound;
    logic [LIM_W-1:0]   steal_limit;
    voice_grant_t       expected_grants[$];
    int                 errors;
    int                 status_seen[8];

    function new();
      for (int i = 0; i < SLOTS; i++) begin
        live[i]  = 1'b0;
        owner[i] = '0;
        age[i]   = '0;
      end
      id_bound    = '0;
      steal_limit = LIMIT_RESET;
      errors      = 0;
      foreach (status_seen[k]) status_seen[k] = 0;
    endfunction

    function void write_reg(cfg_idx_e idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        CFG_SOUND_COUNT:    id_bound    = data[ID_W-1:0];
        CFG_INSTANCE_LIMIT: steal_limit = data[LIM_W-1:0];
        default: ;
      endcase
    endfunction

    // Apply one accepted item to the table and queue its grant
    function void note_item(cmd_e cmd, logic [ID_W-1:0] id, logic [MASK_W-1:0] mask);
      voice_grant_t     grant;
      logic             have_free;
      logic             have_oldest;
      int               free_slot;
      int               oldest_slot;
      int               same_count;
      int               need;
      int               pick;
      logic [AGE_W-1:0] oldest_age;
      grant.slot = '0;
      pick       = 0;
      if (cmd == CMD_TICK) begin
        // Age voices that still play, free everything else
        for (int i = 0; i < SLOTS; i++) begin
          if (live[i] && i < MASK_W && mask[i]) begin
            if (age[i] != AGE_MAX) age[i] = age[i] + 1'b1;
          end else begin
            live[i]  = 1'b0;
            owner[i] = '0;
            age[i]   = '0;
          end
        end
        grant.status = ST_TICK;
      end else if (id == '0 || id >= id_bound) begin
        grant.status = ST_BAD_ID;
      end else begin
        // Scan: last free slot wins, strictly older instance wins
        have_free   = 1'b0;
        have_oldest = 1'b0;
        free_slot   = 0;
        oldest_slot = 0;
        same_count  = 0;
        oldest_age  = '0;
        for (int i = 0; i < SLOTS; i++) begin
          if (!live[i]) begin
            have_free = 1'b1;
            free_slot = i;
          end else if (owner[i] == id) begin
            same_count++;
            if (!have_oldest || age[i] > oldest_age) begin
              have_oldest = 1'b1;
              oldest_age  = age[i];
              oldest_slot = i;
            end
          end
        end
        // A zero limit still needs one live voice to steal
        need = (steal_limit == '0) ? 1 : int'(steal_limit);
        if (have_oldest && same_count >= need) begin
          grant.status = ST_STOLEN;
          pick         = oldest_slot;
        end else if (have_free) begin
          grant.status = ST_FREE;
          pick         = free_slot;
        end else begin
          grant.status = ST_NONE;
        end
        if (grant.status != ST_NONE) begin
          live[pick]  = 1'b1;
          owner[pick] = id;
          age[pick]   = '0;
          grant.slot  = OSLOT_W'(pick);
        end
      end
      expected_grants.push_back(grant);
    endfunction

    // Compare one returned item with the oldest expected grant
    function void check_result(logic [STAT_W-1:0] status, logic [OSLOT_W-1:0] slot);
      voice_grant_t want;
      if (expected_grants.size() == 0) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: unexpected result, status %0d slot %0d", $time, status, slot);
        return;
      end
      want = expected_grants.pop_front();
      status_seen[int'(want.status)]++;
      if (status !== want.status) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: status mismatch, expected %0d (%s) got %0d", $time,
                   want.status, want.status.name(), status);
      end
      if (slot !== want.slot) begin
        errors++;
        if (errors <= PRINT_CAP)
          $display("%0t: slot mismatch, expected %0d got %0d", $time, want.slot, slot);
      end
    endfunction
  endclass

  logic                  clk_i = 1'b0;
  logic                  rst_ni;
  logic                  cfg_we_i;
  logic [CFG_IDX_W-1:0]  cfg_idx_i;
  logic [CFG_DATA_W-1:0] cfg_data_i;

  vsa_req_if req_bus ();
  vsa_rsp_if rsp_bus ();

  voice_table_board board;
  int               send_idle_pct;
  int               recv_stall_pct;
  int               items_sent;
  int               settings_used;
  int               timeout_cycles;

  voice_slot_allocator u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_chan   (req_bus),
    .rsp_chan   (rsp_bus)
  );

  always #5 clk_i = ~clk_i;

  // Offer one item, hold it until taken, then predict its result
  task automatic push_item(input cmd_e cmd, input logic [ID_W-1:0] id,
                           input logic [MASK_W-1:0] mask);
    while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk_i);
    end
    req_bus.valid        <= 1'b1;
    req_bus.cmd          <= cmd;
    req_bus.sound_id     <= id;
    req_bus.playing_mask <= mask;
    do @(posedge clk_i); while (!req_bus.ready);
    board.note_item(cmd, id, mask);
    items_sent++;
  endtask

  // Drop valid and hold until every expected result has come back
  task automatic drain_results();
    req_bus.valid <= 1'b0;
    while (board.expected_grants.size() != 0) @(posedge clk_i);
  endtask

  // Write both registers back to back; call only while idle
  task automatic program_regs(input logic [ID_W-1:0] count, input logic [LIM_W-1:0] limit);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CFG_SOUND_COUNT;
    cfg_data_i <= count;
    @(posedge clk_i);
    board.write_reg(CFG_SOUND_COUNT, count);
    cfg_idx_i  <= CFG_INSTANCE_LIMIT;
    cfg_data_i <= CFG_DATA_W'(limit);
    @(posedge clk_i);
    board.write_reg(CFG_INSTANCE_LIMIT, CFG_DATA_W'(limit));
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // Mostly valid allocations from a small id pool and gentle ticks, plus noise
  task automatic push_random_item(input logic [ID_W-1:0] bound);
    logic [ID_W-1:0]   id;
    logic [MASK_W-1:0] mask;
    int                pool_top;
    int                roll;
    pool_top = (bound > 9) ? 8 : int'(bound) - 1;
    id       = ID_W'($urandom);
    mask     = MASK_W'($urandom);
    roll     = $urandom_range(0, 99);
    if (roll < 58 && pool_top >= 1) begin
      id = ID_W'($urandom_range(1, pool_top));
      push_item(CMD_ALLOC, id, mask);
    end else if (roll < 70) begin
      case ($urandom_range(0, 3))
        0:       id = '0;
        1:       id = bound - 1'b1;
        2:       id = bound;
        default: ;
      endcase
      push_item(CMD_ALLOC, id, mask);
    end else begin
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: mask = '1;
        6, 7, 8:          mask = ~(MASK_W'(1) << $urandom_range(0, MASK_W - 1));
        default:          ;
      endcase
      push_item(CMD_TICK, id, mask);
    end
  endtask

  // One random phase under a fixed setting and idle pattern
  task automatic run_phase(input logic [ID_W-1:0] count, input logic [LIM_W-1:0] limit,
                           input int send_pct, input int recv_pct, input int n_items,
                           input int pause_at);
    drain_results();
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    program_regs(count, limit);
    for (int k = 0; k < n_items; k++) begin
      if (k == pause_at) drain_results();
      push_random_item(count);
    end
  endtask

  // Result side: check accepted items, then pick the next ready
  initial begin
    rsp_bus.ready = 1'b0;
    forever begin
      @(posedge clk_i);
      if (rst_ni && rsp_bus.valid && rsp_bus.ready)
        board.check_result(rsp_bus.status, rsp_bus.slot);
      rsp_bus.ready <= (recv_stall_pct == 0) || ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // Watchdog
  initial begin
    timeout_cycles = 0;
    while (timeout_cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      timeout_cycles++;
    end
    $display("%0t: timeout, %0d results still expected", $time,
             board.expected_grants.size());
    $display("** voice_slot_allocator: FAILED **");
    $finish;
  end

  // Stimulus
  initial begin
    board                = new();
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = CFG_SOUND_COUNT;
    cfg_data_i           = '0;
    req_bus.valid        = 1'b0;
    req_bus.cmd          = CMD_ALLOC;
    req_bus.sound_id     = '0;
    req_bus.playing_mask = '0;
    send_idle_pct        = 0;
    recv_stall_pct       = 0;
    items_sent           = 0;
    settings_used        = 0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Reset setting: every id is out of range, ticks on free slots do nothing
    push_item(CMD_ALLOC, 16'd1, '0);
    push_item(CMD_TICK, '0, '1);
    drain_results();

    // Range edges, grants from the top, tie and age based steals, full clear
    program_regs(16'd10, 6'd2);
    push_item(CMD_ALLOC, 16'd0, '1);
    push_item(CMD_ALLOC, 16'd10, '0);
    push_item(CMD_ALLOC, 16'hFFFF, '0);
    push_item(CMD_ALLOC, 16'd9, '0);
    push_item(CMD_ALLOC, 16'd3, '0);
    push_item(CMD_ALLOC, 16'd3, '0);
    push_item(CMD_TICK, 16'hFFFF, '1);
    push_item(CMD_ALLOC, 16'd3, '0);
    push_item(CMD_TICK, '0, 32'hDFFF_FFFF);
    push_item(CMD_ALLOC, 16'd3, '0);
    push_item(CMD_ALLOC, 16'd3, '0);
    push_item(CMD_TICK, 16'hFFFF, '0);
    push_item(CMD_ALLOC, 16'd9, '0);
    drain_results();

    // Zero limit behaves as one; widest id range
    program_regs(16'hFFFF, 6'd0);
    push_item(CMD_ALLOC, 16'hFFFE, '0);
    push_item(CMD_ALLOC, 16'hFFFE, '0);
    push_item(CMD_ALLOC, 16'd1, '0);
    push_item(CMD_TICK, '0, 32'h5555_AAAA);
    push_item(CMD_TICK, '0, '0);
    drain_results();

    // Limit above the slot count never steals
    program_regs(16'd2, 6'd33);
    push_item(CMD_ALLOC, 16'd1, '0);
    push_item(CMD_ALLOC, 16'd1, '0);
    push_item(CMD_ALLOC, 16'd2, '0);

    // Random phases
    run_phase(16'd16, 6'd4, 0, 0, PHASE_ITEMS, -1);
    run_phase(16'hFFFF, 6'd32, 46, 0, PHASE_ITEMS, PHASE_ITEMS / 2);
    run_phase(16'd5, 6'd1, 0, 46, PHASE_ITEMS, -1);
    run_phase(16'd12, 6'd63, 10, 10, PHASE_ITEMS, -1);
    run_phase(16'd40, 6'd2, 0, 0, PHASE_ITEMS, -1);

    // Let trailing results or stray items show up
    drain_results();
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("Sent %0d items over %0d register settings with idle and stall patterns.",
             items_sent, settings_used + 1);
    $display("Results: %0d granted, %0d stolen, %0d bad id, %0d no slot, %0d ticks.",
             board.status_seen[ST_FREE], board.status_seen[ST_STOLEN],
             board.status_seen[ST_BAD_ID], board.status_seen[ST_NONE],
             board.status_seen[ST_TICK]);
    if (board.errors == 0) begin
      $display("** voice_slot_allocator: PASSED **");
    end else begin
      $display("** voice_slot_allocator: FAILED **");
    end
    $finish;
  end

endmodule
